/* hw/rtl/wrapped_grid_bilinear_height_core_macros.svh */
// Assertion macros shared by the height sampler files.
`ifndef WRAPPED_GRID_BILINEAR_HEIGHT_CORE_MACROS_SVH
`define WRAPPED_GRID_BILINEAR_HEIGHT_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define WGBH_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");
`define WGBH_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define WGBH_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define WGBH_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

/* hw/rtl/wgbh_pkg.sv */
package wgbh_pkg;

   localparam int FRAC_W = 16;
   localparam logic [15:0] HALF_CELL = 16'h8000;

   typedef enum logic {
      MODE_WRITE = 1'b0,
      MODE_QUERY = 1'b1
   } mode_type;

   typedef enum logic [0:0] {
      CSR_GRID_COUNT = 1'b0,
      CSR_CELL_SIZE  = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic        query;
      logic        zero;
      logic [7:0]  cell_x;
      logic [7:0]  cell_z;
      logic [15:0] sample;
   } item_type;

   typedef struct packed {
      item_type item;
      logic     neg;
   } div_side_type;

   typedef struct packed {
      item_type    item;
      logic        neg;
      logic [15:0] frac;
   } mod_side_type;

   typedef struct packed {
      logic        neg;
      logic [15:0] frac;
   } mod_side_z_type;

endpackage

/* hw/rtl/wgbh_udiv.sv */
`include "wrapped_grid_bilinear_height_core_macros.svh"

module wgbh_udiv #(
   parameter int DW = 48,
   parameter int VW = 32,
   parameter int SW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  logic [DW-1:0] in_num,
   input  logic [VW-1:0] divisor,
   input  logic [SW-1:0] in_side,
   output logic          out_valid,
   output logic [DW-1:0] out_quo,
   output logic [VW-1:0] out_rem,
   output logic [SW-1:0] out_side
);

   logic          vld_ff  [1:DW];
   logic [DW-1:0] num_ff  [1:DW];
   logic [DW-1:0] quo_ff  [1:DW];
   logic [VW-1:0] rem_ff  [1:DW];
   logic [SW-1:0] side_ff [1:DW];

   for (genvar k = 0; k < DW; k++) begin : g_stage
      logic          src_vld;
      logic [DW-1:0] src_num;
      logic [DW-1:0] src_quo;
      logic [VW-1:0] src_rem;
      logic [SW-1:0] src_side;
      logic [VW:0]   trial;
      logic [VW:0]   diff;
      logic          ge;
      logic [VW-1:0] rem_in;
      logic [DW-1:0] quo_in;

      if (k == 0) begin : g_first
         assign src_vld  = in_valid;
         assign src_num  = in_num;
         assign src_quo  = '0;
         assign src_rem  = '0;
         assign src_side = in_side;
      end else begin : g_next
         assign src_vld  = vld_ff[k];
         assign src_num  = num_ff[k];
         assign src_quo  = quo_ff[k];
         assign src_rem  = rem_ff[k];
         assign src_side = side_ff[k];
      end

      always_comb begin
         trial  = {src_rem, src_num[DW-1]};
         diff   = trial - {1'b0, divisor};
         ge     = trial >= {1'b0, divisor};
         rem_in = ge ? diff[VW-1:0] : trial[VW-1:0];
         quo_in = {src_quo[DW-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else begin
            vld_ff[k+1] <= src_vld;
         end
         num_ff[k+1]  <= {src_num[DW-2:0], 1'b0};
         quo_ff[k+1]  <= quo_in;
         rem_ff[k+1]  <= rem_in;
         side_ff[k+1] <= src_side;
      end
   end

   assign out_valid = vld_ff[DW];
   assign out_quo   = quo_ff[DW];
   assign out_rem   = rem_ff[DW];
   assign out_side  = side_ff[DW];

   `WGBH_ASSERT_IMP(a_rem_below, clock, reset, out_valid && divisor != '0, out_rem < divisor)
   `WGBH_ASSERT_NEXT(a_no_drop, clock, reset, in_valid, vld_ff[1])
   `WGBH_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !vld_ff[1])

endmodule

/* hw/rtl/wrapped_grid_bilinear_height_core.sv */
// Height sampler over a wrapped square grid. A word with mode 0 stores one sample; a word with
// mode 1 returns the bilinear height at a world position one cycle on rsp_strobe, and a new
// word is taken every cycle while busy is low. The pipeline holds an input stage, two
// bit-serial dividers per axis (48 stages for cell-size division, 32 for wrap modulo) with a
// floor-correction stage between, a wrapped-coordinate stage, then address, memory read and
// weighting, multiply and two summing stages. Writes share the pipeline and reach the store
// at the read stage, so every query sees exactly the writes taken before it. The store is held
// twice, each copy with two read ports. The receiver cannot stall: each result is present
// for one cycle only. busy is high during reset and until the first clock edge after it.
`include "wrapped_grid_bilinear_height_core_macros.svh"

module wrapped_grid_bilinear_height_core #(
   parameter int GRID_MAX = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_mode,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_z,
   input  logic [7:0]         req_cell_x,
   input  logic [7:0]         req_cell_z,
   input  logic signed [15:0] req_sample_value,
   output logic               rsp_strobe,
   output logic signed [15:0] rsp_height,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [0:0]         csr_index,
   input  logic [31:0]        csr_data
);

   localparam int IW = (GRID_MAX > 1) ? $clog2(GRID_MAX) : 1;
   localparam int NW = $clog2(GRID_MAX + 1);
   localparam int AW = 2 * IW;
   localparam int FW = wgbh_pkg::FRAC_W;
   localparam int QW = 32 + FW;
   localparam int DSW = $bits(wgbh_pkg::div_side_type);
   localparam int MSW = $bits(wgbh_pkg::mod_side_type);
   localparam int MZW = $bits(wgbh_pkg::mod_side_z_type);

   logic        busy_ff;
   logic [8:0]  grid_count_ff;
   logic [31:0] cell_size_ff;
   logic [NW-1:0] n_w;
   logic          accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b1;
         grid_count_ff <= '0;
         cell_size_ff  <= '0;
      end else begin
         busy_ff <= 1'b0;
         if (csr_valid && csr_ready) begin
            unique case (wgbh_pkg::csr_index_type'(csr_index))
               wgbh_pkg::CSR_GRID_COUNT: grid_count_ff <= csr_data[8:0];
               wgbh_pkg::CSR_CELL_SIZE:  cell_size_ff  <= csr_data;
            endcase
         end
      end
   end

   assign busy      = busy_ff;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   always_comb begin
      if (32'(grid_count_ff) > 32'(GRID_MAX)) begin
         n_w = NW'(GRID_MAX);
      end else begin
         n_w = NW'(grid_count_ff);
      end
   end

   // Input stage: magnitude and sign of each position.
   logic                a_vld_ff;
   wgbh_pkg::item_type  a_item_ff;
   logic [31:0]         a_mag_ff [2];
   logic                a_neg_ff [2];
   wgbh_pkg::item_type  a_item_in;
   logic [31:0]         px, pz;

   always_comb begin
      px = req_pos_x;
      pz = req_pos_z;
      a_item_in.query  = (req_mode == wgbh_pkg::MODE_QUERY);
      a_item_in.zero   = (n_w == '0) || (cell_size_ff == '0);
      a_item_in.cell_x = req_cell_x;
      a_item_in.cell_z = req_cell_z;
      a_item_in.sample = req_sample_value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= accept;
      end
      a_item_ff   <= a_item_in;
      a_neg_ff[0] <= px[31];
      a_neg_ff[1] <= pz[31];
      a_mag_ff[0] <= px[31] ? (~px + 32'd1) : px;
      a_mag_ff[1] <= pz[31] ? (~pz + 32'd1) : pz;
   end

   // Division by the cell size.
   wgbh_pkg::div_side_type d1x_side_in, d1x_side_out;
   logic [DSW-1:0] d1x_side_bits;
   logic [0:0]     d1z_side_bits;
   logic           d1x_vld, d1z_vld;
   logic [QW-1:0]  d1_quo [2];
   logic [31:0]    d1_rem [2];

   assign d1x_side_in.item = a_item_ff;
   assign d1x_side_in.neg  = a_neg_ff[0];

   wgbh_udiv #(.DW(QW), .VW(32), .SW(DSW)) u_div_x (
      .clock    (clock),
      .reset    (reset),
      .in_valid (a_vld_ff),
      .in_num   ({a_mag_ff[0], {FW{1'b0}}}),
      .divisor  (cell_size_ff),
      .in_side  (d1x_side_in),
      .out_valid(d1x_vld),
      .out_quo  (d1_quo[0]),
      .out_rem  (d1_rem[0]),
      .out_side (d1x_side_bits)
   );

   wgbh_udiv #(.DW(QW), .VW(32), .SW(1)) u_div_z (
      .clock    (clock),
      .reset    (reset),
      .in_valid (a_vld_ff),
      .in_num   ({a_mag_ff[1], {FW{1'b0}}}),
      .divisor  (cell_size_ff),
      .in_side  (a_neg_ff[1]),
      .out_valid(d1z_vld),
      .out_quo  (d1_quo[1]),
      .out_rem  (d1_rem[1]),
      .out_side (d1z_side_bits)
   );

   assign d1x_side_out = wgbh_pkg::div_side_type'(d1x_side_bits);

   // Floor correction for negative positions.
   logic               b_vld_ff;
   wgbh_pkg::item_type b_item_ff;
   logic               b_neg_ff [2];
   logic [QW-1:0]      b_mag_ff [2];
   logic               b_negs [2];

   assign b_negs[0] = d1x_side_out.neg;
   assign b_negs[1] = d1z_side_bits[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else begin
         b_vld_ff <= d1x_vld;
      end
      b_item_ff <= d1x_side_out.item;
      for (int a = 0; a < 2; a++) begin
         b_neg_ff[a] <= b_negs[a];
         b_mag_ff[a] <= d1_quo[a] + QW'(b_negs[a] && (d1_rem[a] != '0));
      end
   end

   // Wrap of the cell index by the grid count.
   wgbh_pkg::mod_side_type   d2x_side_in, d2x_side_out;
   wgbh_pkg::mod_side_z_type d2z_side_in, d2z_side_out;
   logic [MSW-1:0] d2x_side_bits;
   logic [MZW-1:0] d2z_side_bits;
   logic           d2x_vld, d2z_vld;
   logic [31:0]    d2_quo [2];
   logic [NW-1:0]  d2_rem [2];

   assign d2x_side_in.item = b_item_ff;
   assign d2x_side_in.neg  = b_neg_ff[0];
   assign d2x_side_in.frac = b_mag_ff[0][FW-1:0];
   assign d2z_side_in.neg  = b_neg_ff[1];
   assign d2z_side_in.frac = b_mag_ff[1][FW-1:0];

   wgbh_udiv #(.DW(32), .VW(NW), .SW(MSW)) u_mod_x (
      .clock    (clock),
      .reset    (reset),
      .in_valid (b_vld_ff),
      .in_num   (b_mag_ff[0][QW-1:FW]),
      .divisor  (n_w),
      .in_side  (d2x_side_in),
      .out_valid(d2x_vld),
      .out_quo  (d2_quo[0]),
      .out_rem  (d2_rem[0]),
      .out_side (d2x_side_bits)
   );

   wgbh_udiv #(.DW(32), .VW(NW), .SW(MZW)) u_mod_z (
      .clock    (clock),
      .reset    (reset),
      .in_valid (b_vld_ff),
      .in_num   (b_mag_ff[1][QW-1:FW]),
      .divisor  (n_w),
      .in_side  (d2z_side_in),
      .out_valid(d2z_vld),
      .out_quo  (d2_quo[1]),
      .out_rem  (d2_rem[1]),
      .out_side (d2z_side_bits)
   );

   assign d2x_side_out = wgbh_pkg::mod_side_type'(d2x_side_bits);
   assign d2z_side_out = wgbh_pkg::mod_side_z_type'(d2z_side_bits);

   // Wrapped coordinate: index and fraction per axis.
   logic               c_vld_ff;
   wgbh_pkg::item_type c_item_ff;
   logic [IW-1:0]      c_idx_ff [2];
   logic [FW-1:0]      c_frac_ff [2];
   logic [NW+FW-1:0]   c_r [2];
   logic [NW+FW-1:0]   c_w [2];
   logic               c_negs [2];

   always_comb begin
      c_negs[0] = d2x_side_out.neg;
      c_negs[1] = d2z_side_out.neg;
      c_r[0]    = {d2_rem[0], d2x_side_out.frac};
      c_r[1]    = {d2_rem[1], d2z_side_out.frac};
      for (int a = 0; a < 2; a++) begin
         if (c_negs[a] && (c_r[a] != '0)) begin
            c_w[a] = {n_w, {FW{1'b0}}} - c_r[a];
         end else begin
            c_w[a] = c_r[a];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
      end else begin
         c_vld_ff <= d2x_vld;
      end
      c_item_ff <= d2x_side_out.item;
      for (int a = 0; a < 2; a++) begin
         c_idx_ff[a]  <= c_w[a][IW+FW-1:FW];
         c_frac_ff[a] <= c_w[a][FW-1:0];
      end
   end

   // Neighbour samples and weights per axis.
   logic               d_vld_ff;
   wgbh_pkg::item_type d_item_ff;
   logic [IW-1:0]      d_lo_ff [2];
   logic [IW-1:0]      d_hi_ff [2];
   logic [FW-1:0]      d_wt_ff [2];
   logic [IW-1:0]      d_lo_in [2];
   logic [IW-1:0]      d_hi_in [2];
   logic [FW-1:0]      d_wt_in [2];
   logic [NW-1:0]      d_nm1;
   logic [NW-1:0]      d_ip1 [2];

   always_comb begin
      d_nm1 = n_w - NW'(1);
      for (int a = 0; a < 2; a++) begin
         d_ip1[a] = NW'(c_idx_ff[a]) + NW'(1);
         if (c_frac_ff[a] < wgbh_pkg::HALF_CELL) begin
            d_lo_in[a] = (c_idx_ff[a] == '0) ? d_nm1[IW-1:0] : (c_idx_ff[a] - IW'(1));
            d_hi_in[a] = c_idx_ff[a];
            d_wt_in[a] = c_frac_ff[a] + wgbh_pkg::HALF_CELL;
         end else if (c_frac_ff[a] > wgbh_pkg::HALF_CELL) begin
            d_lo_in[a] = c_idx_ff[a];
            d_hi_in[a] = (d_ip1[a] == n_w) ? '0 : d_ip1[a][IW-1:0];
            d_wt_in[a] = c_frac_ff[a] - wgbh_pkg::HALF_CELL;
         end else begin
            d_lo_in[a] = c_idx_ff[a];
            d_hi_in[a] = c_idx_ff[a];
            d_wt_in[a] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_vld_ff <= 1'b0;
      end else begin
         d_vld_ff <= c_vld_ff;
      end
      d_item_ff <= c_item_ff;
      for (int a = 0; a < 2; a++) begin
         d_lo_ff[a] <= d_lo_in[a];
         d_hi_ff[a] <= d_hi_in[a];
         d_wt_ff[a] <= d_wt_in[a];
      end
   end

   // Sample store and weight products.
   logic [15:0]     mem_a [0:(1 << AW)-1];
   logic [15:0]     mem_b [0:(1 << AW)-1];
   logic [IW+7:0]   wr_x, wr_z;
   logic [AW-1:0]   wr_addr;
   logic            wr_en;
   logic [FW:0]     cw [2];
   logic [FW:0]     ww [2];

   always_comb begin
      wr_x    = {{IW{1'b0}}, d_item_ff.cell_x};
      wr_z    = {{IW{1'b0}}, d_item_ff.cell_z};
      wr_addr = {wr_x[IW-1:0], wr_z[IW-1:0]};
      wr_en   = d_vld_ff && !d_item_ff.query
             && (32'(d_item_ff.cell_x) < 32'(GRID_MAX))
             && (32'(d_item_ff.cell_z) < 32'(GRID_MAX));
      for (int a = 0; a < 2; a++) begin
         ww[a] = {1'b0, d_wt_ff[a]};
         cw[a] = {1'b1, {FW{1'b0}}} - ww[a];
      end
   end

   logic               e_vld_ff;
   wgbh_pkg::item_type e_item_ff;
   logic [15:0]        e_s_ff [4];
   logic [2*FW+1:0]    e_p_ff [4];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_a[wr_addr] <= d_item_ff.sample;
         mem_b[wr_addr] <= d_item_ff.sample;
      end
      e_s_ff[0] <= mem_a[{d_lo_ff[0], d_lo_ff[1]}];
      e_s_ff[1] <= mem_a[{d_hi_ff[0], d_lo_ff[1]}];
      e_s_ff[2] <= mem_b[{d_lo_ff[0], d_hi_ff[1]}];
      e_s_ff[3] <= mem_b[{d_hi_ff[0], d_hi_ff[1]}];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_vld_ff <= 1'b0;
      end else begin
         e_vld_ff <= d_vld_ff;
      end
      e_item_ff <= d_item_ff;
      e_p_ff[0] <= cw[0] * cw[1];
      e_p_ff[1] <= ww[0] * cw[1];
      e_p_ff[2] <= cw[0] * ww[1];
      e_p_ff[3] <= ww[0] * ww[1];
   end

   // Sample times weight, then the sum and rounding.
   logic                f_vld_ff;
   wgbh_pkg::item_type  f_item_ff;
   logic signed [50:0]  f_prod_ff [4];

   always_ff @(posedge clock) begin
      if (reset) begin
         f_vld_ff <= 1'b0;
      end else begin
         f_vld_ff <= e_vld_ff;
      end
      f_item_ff <= e_item_ff;
      for (int k = 0; k < 4; k++) begin
         f_prod_ff[k] <= $signed(e_s_ff[k]) * $signed({1'b0, e_p_ff[k]});
      end
   end

   logic                g_vld_ff;
   wgbh_pkg::item_type  g_item_ff;
   logic signed [50:0]  g_sum_ff [2];

   always_ff @(posedge clock) begin
      if (reset) begin
         g_vld_ff <= 1'b0;
      end else begin
         g_vld_ff <= f_vld_ff;
      end
      g_item_ff   <= f_item_ff;
      g_sum_ff[0] <= f_prod_ff[0] + f_prod_ff[1];
      g_sum_ff[1] <= f_prod_ff[2] + f_prod_ff[3];
   end

   logic               h_strobe_ff;
   logic signed [15:0] h_height_ff;
   logic signed [50:0] h_total;

   assign h_total = g_sum_ff[0] + g_sum_ff[1] + 51'sh80000000;

   always_ff @(posedge clock) begin
      if (reset) begin
         h_strobe_ff <= 1'b0;
      end else begin
         h_strobe_ff <= g_vld_ff && g_item_ff.query;
      end
      h_height_ff <= g_item_ff.zero ? 16'sd0 : h_total[47:32];
   end

   assign rsp_strobe = h_strobe_ff;
   assign rsp_height = h_height_ff;

   `WGBH_ASSERT_IMP(a_axes_aligned, clock, reset, 1'b1, (d1x_vld == d1z_vld) && (d2x_vld == d2z_vld))
   `WGBH_ASSERT_IMP(a_lo_in_grid, clock, reset, d_vld_ff && d_item_ff.query && !d_item_ff.zero, (NW'(d_lo_ff[0]) < n_w) && (NW'(d_lo_ff[1]) < n_w))
   `WGBH_ASSERT_NEXT(a_strobe_query, clock, reset, !(g_vld_ff && g_item_ff.query), !rsp_strobe)
   `WGBH_ASSERT_IMP(a_no_write_at_query, clock, reset, wr_en, !d_item_ff.query)

endmodule
